// ===== rtl/dipc_pkg.sv =====
package dipc_pkg;

    localparam int LEVEL_BITS       = 12;
    localparam int TIMER_BITS       = 24;
    localparam int RAMP_STEPS       = 10;
    localparam int STEP_INTERVAL_MS = 150;
    localparam int WAKE_GAP_MS      = 200;
    localparam int TICK_BITS        = 8;
    localparam int GAP_BITS         = 8;

    // x / RAMP_STEPS as (x * DIV_RECIP) >> DIV_SHIFT, exact for any LEVEL_BITS-wide x
    localparam int DIV_SHIFT       = LEVEL_BITS + $clog2(RAMP_STEPS);
    localparam int DIV_RECIP_BITS  = DIV_SHIFT + 1;
    localparam int DIV_RECIP       = ((2 ** DIV_SHIFT) + RAMP_STEPS - 1) / RAMP_STEPS;
    localparam int DIV_PROD_BITS   = LEVEL_BITS + DIV_RECIP_BITS;

    localparam int CFG_IDX_BITS    = 2;
    localparam int CFG_DATA_BITS   = TIMER_BITS;
    localparam int IN_DATA_BITS    = 16;
    localparam int OUT_DATA_BITS   = 24;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_IDLE_TIMEOUT = 2'd0,
        CFG_OFF_TIMEOUT  = 2'd1,
        CFG_DIM_TARGET   = 2'd2,
        CFG_BL_PRESENT   = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_EVENT = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        EV_KEY    = 2'd0,
        EV_MOVE   = 2'd1,
        EV_OTHER  = 2'd2,
        EV_SPARE  = 2'd3
    } event_kind_t;

    typedef struct packed {
        logic                  activity_seen;
        logic                  suspend_request;
        logic                  panel_on_pulse;
        logic                  panel_off_pulse;
        logic                  panel_powered;
        logic [LEVEL_BITS-1:0] backlight_level;
        logic                  level_write;
    } result_t;

endpackage

// ===== rtl/display_idle_power_controller.sv =====
// An accepted item passes the input register, then the result register; the countdowns, ramp step
// and divide-by-steps fit in one pass. Throughput: one item per cycle unless m_tready stalls.
// The result register decouples the sides: a new item is taken while a result waits.
// Reset (rst_n low, asynchronous): timers stopped, panel on, no ramp, all timeouts zero,
// wake gap counter saturated.
module display_idle_power_controller (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [dipc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [dipc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [1:0] event_kind, [13:2] panel_level, [15:14] zero
    input  logic [dipc_pkg::IN_DATA_BITS-1:0]   s_tdata,
    // [0] opcode
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] level_write, [12:1] backlight_level, [13] panel_powered, [14] panel_off_pulse,
    // [15] panel_on_pulse, [16] suspend_request, [17] activity_seen, [23:18] zero
    output logic [dipc_pkg::OUT_DATA_BITS-1:0]  m_tdata
);
    import dipc_pkg::*;

    localparam int RES_BITS = $bits(result_t);

    // configuration
    logic [TIMER_BITS-1:0] idle_timeout_reg;
    logic [TIMER_BITS-1:0] off_timeout_reg;
    logic [LEVEL_BITS-1:0] dim_target_reg;
    logic                  bl_present_reg;

    // input stage
    logic                  in_valid_reg;
    opcode_t               in_op_reg;
    event_kind_t           in_kind_reg;
    logic [LEVEL_BITS-1:0] in_level_reg;

    // state
    logic [TIMER_BITS-1:0] off_cd_reg, off_cd_next;
    logic                  off_run_reg, off_run_next;
    logic [TIMER_BITS-1:0] idle_cd_reg, idle_cd_next;
    logic                  idle_run_reg, idle_run_next;
    logic                  panel_off_reg, panel_off_next;
    logic                  ramp_active_reg, ramp_active_next;
    logic [LEVEL_BITS-1:0] ramp_level_reg, ramp_level_next;
    logic [LEVEL_BITS-1:0] ramp_step_reg, ramp_step_next;
    logic [LEVEL_BITS-1:0] saved_level_reg, saved_level_next;
    logic [TICK_BITS-1:0]  tick_cnt_reg, tick_cnt_next;
    logic [GAP_BITS-1:0]   since_wake_reg, since_wake_next;

    // output stage
    logic                  out_valid_reg;
    result_t               res_reg;
    result_t               res_next;

    logic                  advance;
    logic                  in_take;
    logic [LEVEL_BITS-1:0]    dim_diff;
    logic [DIV_PROD_BITS-1:0] dim_prod;
    logic [LEVEL_BITS-1:0]    dim_quot;
    logic [TICK_BITS-1:0]     tick_inc;
    logic [TIMER_BITS-1:0]    off_dec;
    logic [TIMER_BITS-1:0]    idle_dec;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_BITS-RES_BITS){1'b0}}, res_reg};

    // step = max((sample - target) / RAMP_STEPS, 1)
    assign dim_diff = in_level_reg - dim_target_reg;
    assign dim_prod = DIV_PROD_BITS'(dim_diff) * DIV_PROD_BITS'(DIV_RECIP);
    assign dim_quot = dim_prod[DIV_SHIFT +: LEVEL_BITS];

    assign tick_inc = tick_cnt_reg + 1'b1;
    assign off_dec  = off_cd_reg - 1'b1;
    assign idle_dec = idle_cd_reg - 1'b1;

    always_comb
    begin
        off_cd_next      = off_cd_reg;
        off_run_next     = off_run_reg;
        idle_cd_next     = idle_cd_reg;
        idle_run_next    = idle_run_reg;
        panel_off_next   = panel_off_reg;
        ramp_active_next = ramp_active_reg;
        ramp_level_next  = ramp_level_reg;
        ramp_step_next   = ramp_step_reg;
        saved_level_next = saved_level_reg;
        tick_cnt_next    = tick_cnt_reg;
        since_wake_next  = since_wake_reg;
        res_next         = '0;

        unique case (in_op_reg)
            OP_TICK:
            begin
                if (since_wake_reg <= GAP_BITS'(WAKE_GAP_MS))
                    since_wake_next = since_wake_reg + 1'b1;
                // ramp step
                if (ramp_active_reg)
                begin
                    tick_cnt_next = tick_inc;
                    if (tick_inc >= TICK_BITS'(STEP_INTERVAL_MS))
                    begin
                        tick_cnt_next        = '0;
                        res_next.level_write = 1'b1;
                        if (ramp_level_reg <= dim_target_reg ||
                            (ramp_level_reg - dim_target_reg) <= ramp_step_reg)
                        begin
                            res_next.backlight_level = dim_target_reg;
                            ramp_active_next         = 1'b0;
                            panel_off_next           = 1'b1;
                            res_next.panel_off_pulse = 1'b1;
                        end
                        else
                        begin
                            ramp_level_next          = ramp_level_reg - ramp_step_reg;
                            res_next.backlight_level = ramp_level_reg - ramp_step_reg;
                        end
                    end
                end
                // display-off expiry, may restart the ramp
                if (off_run_reg)
                begin
                    off_cd_next = off_dec;
                    if (off_dec == '0)
                    begin
                        off_run_next = 1'b0;
                        if (off_timeout_reg != '0 && bl_present_reg)
                        begin
                            saved_level_next = in_level_reg;
                            if (in_level_reg != '0)
                            begin
                                ramp_active_next = 1'b0;
                                if (in_level_reg > dim_target_reg)
                                begin
                                    ramp_step_next   = (dim_quot == '0) ?
                                                       LEVEL_BITS'(1) : dim_quot;
                                    ramp_level_next  = in_level_reg;
                                    tick_cnt_next    = '0;
                                    ramp_active_next = 1'b1;
                                end
                            end
                        end
                    end
                end
                // idle expiry
                if (idle_run_reg)
                begin
                    idle_cd_next = idle_dec;
                    if (idle_dec == '0)
                    begin
                        idle_run_next = 1'b0;
                        if (idle_timeout_reg != '0)
                            res_next.suspend_request = 1'b1;
                    end
                end
            end
            OP_EVENT:
            begin
                if ((idle_timeout_reg != '0 || off_timeout_reg != '0) &&
                    (in_kind_reg == EV_KEY || (in_kind_reg == EV_MOVE && panel_off_reg)))
                begin
                    res_next.activity_seen = 1'b1;
                    if (panel_off_reg)
                    begin
                        if (since_wake_reg > GAP_BITS'(WAKE_GAP_MS))
                        begin
                            ramp_active_next = 1'b0;
                            if (saved_level_reg != '0)
                            begin
                                res_next.level_write     = 1'b1;
                                res_next.backlight_level = saved_level_reg;
                            end
                            res_next.panel_on_pulse = 1'b1;
                            panel_off_next          = 1'b0;
                        end
                        since_wake_next = '0;
                    end
                    else if (ramp_active_reg)
                    begin
                        ramp_active_next         = 1'b0;
                        res_next.level_write     = 1'b1;
                        res_next.backlight_level = saved_level_reg;
                    end
                    if (off_timeout_reg != '0)
                    begin
                        off_cd_next  = off_timeout_reg;
                        off_run_next = 1'b1;
                    end
                    if (idle_timeout_reg != '0)
                    begin
                        idle_cd_next  = idle_timeout_reg;
                        idle_run_next = 1'b1;
                    end
                end
            end
            default:
            begin
                res_next = '0;
            end
        endcase

        res_next.panel_powered = !panel_off_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_timeout_reg <= '0;
            off_timeout_reg  <= '0;
            dim_target_reg   <= '0;
            bl_present_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_IDLE_TIMEOUT: idle_timeout_reg <= cfg_data;
                CFG_OFF_TIMEOUT:  off_timeout_reg  <= cfg_data;
                CFG_DIM_TARGET:   dim_target_reg   <= cfg_data[LEVEL_BITS-1:0];
                CFG_BL_PRESENT:   bl_present_reg   <= cfg_data[0];
                default:          bl_present_reg   <= bl_present_reg;
            endcase
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_op_reg    <= opcode_t'(s_tuser);
            in_kind_reg  <= event_kind_t'(s_tdata[1:0]);
            in_level_reg <= s_tdata[2 +: LEVEL_BITS];
        end
    end

    // state and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_cd_reg      <= '0;
            off_run_reg     <= 1'b0;
            idle_cd_reg     <= '0;
            idle_run_reg    <= 1'b0;
            panel_off_reg   <= 1'b0;
            ramp_active_reg <= 1'b0;
            ramp_level_reg  <= '0;
            ramp_step_reg   <= '0;
            saved_level_reg <= '0;
            tick_cnt_reg    <= '0;
            since_wake_reg  <= GAP_BITS'(WAKE_GAP_MS + 1);
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                off_cd_reg      <= off_cd_next;
                off_run_reg     <= off_run_next;
                idle_cd_reg     <= idle_cd_next;
                idle_run_reg    <= idle_run_next;
                panel_off_reg   <= panel_off_next;
                ramp_active_reg <= ramp_active_next;
                ramp_level_reg  <= ramp_level_next;
                ramp_step_reg   <= ramp_step_next;
                saved_level_reg <= saved_level_next;
                tick_cnt_reg    <= tick_cnt_next;
                since_wake_reg  <= since_wake_next;
                out_valid_reg   <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    // checks
    a_off_unpowered: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.panel_off_pulse |-> !res_reg.panel_powered)
        else $error("panel off pulse with panel powered");

    a_on_from_activity: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.panel_on_pulse |->
            res_reg.panel_powered && res_reg.activity_seen)
        else $error("panel on pulse without activity or power");

    a_level_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res_reg.level_write |-> res_reg.backlight_level == '0)
        else $error("backlight level set without write");

    a_ramp_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ramp_active_reg |-> ramp_step_reg != '0)
        else $error("ramp running with zero step");

endmodule
